@@ rtl/core/cspu_pkg.sv @@
// Package for the call-stack cycle profiler: field widths, codes, state type
// and default sizes shared by the top level and the table memories.
// No dependencies.
package cspu_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_FUNCTIONS_DEF = 256;
  localparam int STACK_DEPTH_DEF   = 32;
  localparam int COUNTER_WIDTH_DEF = 48;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int ID_W     = 8;
  localparam int ID_SPAN  = 1 << ID_W;
  localparam int STAMP_W  = 48;
  localparam int CALLS_W  = 32;
  localparam int DEPTH_W  = 6;
  localparam int STATUS_W = 2;
  localparam int OVH_W    = 16;

  // Event commands; the unused code behaves as a read
  localparam logic [CMD_W-1:0] CMD_ENTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXIT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STACK_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ONLY_ROOT  = 2'd2;

  typedef enum logic [2:0] {
    FSM_CLEAR = 3'b001,
    FSM_IDLE  = 3'b010,
    FSM_EXEC  = 3'b100
  } fsm_t;

  // Write enables for the two counter tables
  typedef struct packed {
    logic cyc;
    logic call;
  } tbl_we_t;

endpackage

@@ rtl/core/call_stack_cycle_profiler_unit.sv @@
// Call-stack cycle profiler, top level. Depends on cspu_pkg and cspu_tables.
// The accepted event and the counter table reads are registered; execute writes
// back the tables and registers the result beat. Events are taken only in idle
// with the result slot free or draining, so none overlaps a read-then-write.
// Reset: synchronous, active low; afterwards a clearing pass over all NUM_FUNCTIONS
// entries zeroes both tables while in_ready stays low (config writes still taken).
module call_stack_cycle_profiler_unit
  import cspu_pkg::*;
#(
  parameter int NUM_FUNCTIONS = NUM_FUNCTIONS_DEF,
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // event channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [ID_W-1:0]     in_function_id,
  input  logic [STAMP_W-1:0]  in_timestamp,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STAMP_W-1:0]  out_entry_cycles,
  output logic [CALLS_W-1:0]  out_entry_calls,
  output logic [STAMP_W-1:0]  out_grand_total,
  output logic [DEPTH_W-1:0]  out_nesting_depth,
  output logic [STATUS_W-1:0] out_status,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [OVH_W-1:0]    cfg_wr_data
);

  localparam int FW   = (NUM_FUNCTIONS > 1) ? $clog2(NUM_FUNCTIONS) : 1;
  localparam int SW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW   = $clog2(STACK_DEPTH + 1);
  localparam int CW   = COUNTER_WIDTH;
  localparam int SUMW = ((CW > STAMP_W) ? CW : STAMP_W) + 1;
  localparam logic [CW-1:0] CNT_MAX  = '1;
  localparam logic [FW-1:0] LAST_FN  = FW'(NUM_FUNCTIONS - 1);
  localparam logic [DW-1:0] DEPTH_MAX = DW'(STACK_DEPTH);

  // ------------------------------------------------------------------
  // Control and architectural registers
  // ------------------------------------------------------------------
  fsm_t               state_r, state_nxt;
  logic [FW-1:0]      clr_idx_r, clr_idx_nxt;
  logic [OVH_W-1:0]   overhead_r;
  logic [DW-1:0]      depth_r, depth_nxt;
  logic [FW-1:0]      top_r, top_nxt;
  logic [CW-1:0]      total_r, total_nxt;
  logic [STAMP_W-1:0] last_stamp_r, last_stamp_nxt;
  logic               out_valid_r;

  // Event held during the execute cycle
  logic [CMD_W-1:0]   cmd_r;
  logic [FW-1:0]      id_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [STAMP_W-1:0] elapsed_r;

  // Result beat register
  logic [STAMP_W-1:0]  res_cycles_r;
  logic [CALLS_W-1:0]  res_calls_r;
  logic [STAMP_W-1:0]  res_total_r;
  logic [DEPTH_W-1:0]  res_depth_r;
  logic [STATUS_W-1:0] res_status_r;

  logic accept;
  logic exec;
  logic clearing;

  assign clearing = (state_r == FSM_CLEAR);
  assign exec     = (state_r == FSM_EXEC);
  // Take a new event only when idle and the result slot is free or draining
  assign in_ready = (state_r == FSM_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // ------------------------------------------------------------------
  // Id to table entry: constant table folding ids beyond the table size
  // ------------------------------------------------------------------
  logic [FW-1:0] id_fold [ID_SPAN];
  for (genvar g = 0; g < ID_SPAN; g++) begin : g_fold
    assign id_fold[g] = FW'(g % NUM_FUNCTIONS);
  end

  logic [FW-1:0] in_id;
  assign in_id = id_fold[in_function_id];

  // ------------------------------------------------------------------
  // Stack of frame ids. Slot zero is the root and its memory entry is never
  // used: a pop back to depth one restores root directly.
  // ------------------------------------------------------------------
  logic [FW-1:0] frame_mem [STACK_DEPTH];
  logic [FW-1:0] below_top_q;
  logic [DW-1:0] depth_m2;
  logic          push_we;

  assign depth_m2 = depth_r - DW'(2);

  always_ff @(posedge clk) begin
    if (push_we) begin
      frame_mem[depth_r[SW-1:0]] <= id_r;
    end
    if (accept) begin
      below_top_q <= frame_mem[depth_m2[SW-1:0]];
    end
  end

  // ------------------------------------------------------------------
  // Counter tables
  // ------------------------------------------------------------------
  logic [CW-1:0]      cyc_top_q, cyc_id_q;
  logic [CALLS_W-1:0] call_id_q;
  tbl_we_t            tbl_we;
  logic [FW-1:0]      cyc_wr_addr, call_wr_addr;
  logic [CW-1:0]      cyc_wr_data;
  logic [CALLS_W-1:0] call_wr_data;

  cspu_tables #(
    .NUM_FUNCTIONS (NUM_FUNCTIONS),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_tables (
    .clk          (clk),
    .rd_en        (accept),
    .rd_top_addr  (top_r),
    .rd_id_addr   (in_id),
    .cyc_top_q    (cyc_top_q),
    .cyc_id_q     (cyc_id_q),
    .call_id_q    (call_id_q),
    .we           (tbl_we),
    .cyc_wr_addr  (cyc_wr_addr),
    .cyc_wr_data  (cyc_wr_data),
    .call_wr_addr (call_wr_addr),
    .call_wr_data (call_wr_data)
  );

  // ------------------------------------------------------------------
  // Execute cycle: charge the top frame, count the call, move the stack
  // ------------------------------------------------------------------
  logic               is_enter, is_exit;
  logic               do_enter, do_exit, do_charge;
  logic [STAMP_W-1:0] ovh_ext, charge;
  logic [SUMW-1:0]    top_sum, total_sum;
  logic [CW-1:0]      top_new, total_new;
  logic [CALLS_W-1:0] call_new;
  logic [CW-1:0]      ent_cycles;
  logic [CALLS_W-1:0] ent_calls;
  logic [STATUS_W-1:0] status;
  logic [CW+STAMP_W-1:0] ent_cycles_ext, total_ext;
  logic [DW+DEPTH_W-1:0] depth_ext;

  assign is_enter  = (cmd_r == CMD_ENTER);
  assign is_exit   = (cmd_r == CMD_EXIT);
  assign do_enter  = is_enter && (depth_r < DEPTH_MAX);
  assign do_exit   = is_exit && (depth_r > DW'(1));
  assign do_charge = do_enter || do_exit;

  // Overhead only trims entry intervals, and never below zero
  assign ovh_ext = STAMP_W'(overhead_r);
  always_comb begin
    if (!is_enter) begin
      charge = elapsed_r;
    end else if (elapsed_r > ovh_ext) begin
      charge = elapsed_r - ovh_ext;
    end else begin
      charge = '0;
    end
  end

  // Saturating accumulation
  assign top_sum   = SUMW'(cyc_top_q) + SUMW'(charge);
  assign total_sum = SUMW'(total_r) + SUMW'(charge);
  assign top_new   = (top_sum > SUMW'(CNT_MAX)) ? CNT_MAX : CW'(top_sum);
  assign total_new = (total_sum > SUMW'(CNT_MAX)) ? CNT_MAX : CW'(total_sum);
  assign call_new  = (&call_id_q) ? call_id_q : call_id_q + CALLS_W'(1);

  // Report the addressed entry as it stands after this event
  assign ent_cycles = (do_charge && (id_r == top_r)) ? top_new : cyc_id_q;
  assign ent_calls  = do_enter ? call_new : call_id_q;

  always_comb begin
    if (is_enter && !do_enter) begin
      status = ST_STACK_FULL;
    end else if (is_exit && !do_exit) begin
      status = ST_ONLY_ROOT;
    end else begin
      status = ST_OK;
    end
  end

  assign ent_cycles_ext = {{STAMP_W{1'b0}}, ent_cycles};
  assign total_ext      = {{STAMP_W{1'b0}}, total_nxt};
  assign depth_ext      = {{DEPTH_W{1'b0}}, depth_nxt};

  // Table write port: clearing sweep after reset, write-back in execute
  assign push_we = exec && do_enter;
  always_comb begin
    if (clearing) begin
      tbl_we       = '{cyc: 1'b1, call: 1'b1};
      cyc_wr_addr  = clr_idx_r;
      call_wr_addr = clr_idx_r;
      cyc_wr_data  = '0;
      call_wr_data = '0;
    end else begin
      tbl_we       = '{cyc: exec && do_charge, call: exec && do_enter};
      cyc_wr_addr  = top_r;
      call_wr_addr = id_r;
      cyc_wr_data  = top_new;
      call_wr_data = call_new;
    end
  end

  // ------------------------------------------------------------------
  // Next-state logic
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    depth_nxt      = depth_r;
    top_nxt        = top_r;
    total_nxt      = total_r;
    last_stamp_nxt = last_stamp_r;
    case (state_r)
      FSM_CLEAR: begin
        clr_idx_nxt = clr_idx_r + FW'(1);
        if (clr_idx_r == LAST_FN) begin
          state_nxt = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        if (accept) begin
          state_nxt = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        state_nxt = FSM_IDLE;
        if (do_charge) begin
          total_nxt      = total_new;
          last_stamp_nxt = stamp_r;
        end
        if (do_enter) begin
          depth_nxt = depth_r + DW'(1);
          top_nxt   = id_r;
        end else if (do_exit) begin
          depth_nxt = depth_r - DW'(1);
          // drop to root when only root remains below
          top_nxt   = (depth_r == DW'(2)) ? '0 : below_top_q;
        end
      end
      default: begin
        state_nxt = FSM_CLEAR;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FSM_CLEAR;
      clr_idx_r    <= '0;
      overhead_r   <= '0;
      depth_r      <= DW'(1);
      top_r        <= '0;
      total_r      <= '0;
      last_stamp_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      depth_r      <= depth_nxt;
      top_r        <= top_nxt;
      total_r      <= total_nxt;
      last_stamp_r <= last_stamp_nxt;
      if (cfg_wr_en) begin
        overhead_r <= cfg_wr_data;
      end
      // Load the result beat at the end of execute, drop it once taken
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the accepted event and the interval since the last charged event
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_cmd;
      id_r      <= in_id;
      stamp_r   <= in_timestamp;
      elapsed_r <= in_timestamp - last_stamp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      res_cycles_r <= ent_cycles_ext[STAMP_W-1:0];
      res_calls_r  <= ent_calls;
      res_total_r  <= total_ext[STAMP_W-1:0];
      res_depth_r  <= depth_ext[DEPTH_W-1:0];
      res_status_r <= status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_entry_cycles  = res_cycles_r;
  assign out_entry_calls   = res_calls_r;
  assign out_grand_total   = res_total_r;
  assign out_nesting_depth = res_depth_r;
  assign out_status        = res_status_r;

endmodule

@@ rtl/core/cspu_tables.sv @@
// Counter table memories of the profiler: cycle totals (two read ports) and
// call counts (one read port), each with one write port and registered reads.
// Depends on cspu_pkg.
module cspu_tables
  import cspu_pkg::*;
#(
  parameter int NUM_FUNCTIONS = NUM_FUNCTIONS_DEF,
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF,
  localparam int FW = (NUM_FUNCTIONS > 1) ? $clog2(NUM_FUNCTIONS) : 1
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [FW-1:0]            rd_top_addr,
  input  logic [FW-1:0]            rd_id_addr,
  output logic [COUNTER_WIDTH-1:0] cyc_top_q,
  output logic [COUNTER_WIDTH-1:0] cyc_id_q,
  output logic [CALLS_W-1:0]       call_id_q,
  input  tbl_we_t                  we,
  input  logic [FW-1:0]            cyc_wr_addr,
  input  logic [COUNTER_WIDTH-1:0] cyc_wr_data,
  input  logic [FW-1:0]            call_wr_addr,
  input  logic [CALLS_W-1:0]       call_wr_data
);

  logic [COUNTER_WIDTH-1:0] cyc_mem  [NUM_FUNCTIONS];
  logic [CALLS_W-1:0]       call_mem [NUM_FUNCTIONS];

  always_ff @(posedge clk) begin
    if (we.cyc) begin
      cyc_mem[cyc_wr_addr] <= cyc_wr_data;
    end
    if (rd_en) begin
      cyc_top_q <= cyc_mem[rd_top_addr];
      cyc_id_q  <= cyc_mem[rd_id_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we.call) begin
      call_mem[call_wr_addr] <= call_wr_data;
    end
    if (rd_en) begin
      call_id_q <= call_mem[rd_id_addr];
    end
  end

endmodule
